/* hdl/lidar_segment_cylinder_detector_unit_macros.svh */
// Assertion macros shared by the lidar cylinder detector RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LIDAR_SEGMENT_CYLINDER_DETECTOR_UNIT_MACROS_SVH
`define LIDAR_SEGMENT_CYLINDER_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define LSCD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check.
`define LSCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LSCD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LSCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/lscd_pkg.sv */
// Shared types and constants of the lidar cylinder detector.
// No dependencies; used by the sine ROM, the serial multiplier and the top level.
package lscd_pkg;

   localparam int RANGE_BITS    = 16;
   localparam int TRIG_BITS     = 18;
   localparam int TRIG_FRAC     = 17;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CENTER_BITS   = 17;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [TRIG_BITS-1:0] TRIG_ONE = 18'h20000;

   // pi/2 in Q28, base of the quarter-wave table.
   localparam longint HALF_PI_Q28 = 64'sd421657428;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_START_ANGLE        = 3'd0,
      REG_ANGLE_STEP         = 3'd1,
      REG_MAX_RANGE          = 3'd2,
      REG_GAP_THRESHOLD      = 3'd3,
      REG_TARGET_DIAMETER    = 3'd4,
      REG_DIAMETER_TOLERANCE = 3'd5,
      REG_MIN_POINTS         = 3'd6
   } csr_reg_type;

   localparam logic [31:0] START_ANGLE_RESET    = 32'd0;
   localparam logic [31:0] ANGLE_STEP_RESET     = 32'd0;
   localparam logic [15:0] MAX_RANGE_RESET      = 16'd65535;
   localparam logic [15:0] GAP_THRESHOLD_RESET  = 16'd900;
   localparam logic [15:0] TARGET_DIAM_RESET    = 16'd300;
   localparam logic [15:0] DIAM_TOLERANCE_RESET = 16'd50;
   localparam logic [2:0]  MIN_POINTS_RESET     = 3'd4;

   localparam logic [2:0] SEG_FLOOR_POINTS = 3'd2;
   localparam logic [2:0] COUNT_MAX        = 3'd7;

   typedef struct packed {
      logic                 neg;
      logic [TRIG_BITS-1:0] mag;
   } trig_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

/* hdl/lscd_sine_rom.sv */
// Quarter-wave sine ROM with quadrant folding, registered read through an address register and a data register.
// Depends on lscd_pkg for the trig word format and the pi/2 constant.
module lscd_sine_rom #(
   parameter int DEPTH = 1024
) (
   input  logic               clock,
   input  logic [31:0]        angle,
   output lscd_pkg::trig_type trig
);

   localparam int AW = $clog2(DEPTH);
   localparam int SCW = 30 + AW + 1;
   localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

   logic [lscd_pkg::TRIG_BITS-1:0] sine_tab [DEPTH];

   // Table entries come from a seven-term Taylor series in Q28, rounded to Q17.
   for (genvar k = 0; k < DEPTH; k++) begin : g_tab
      localparam longint X  = (lscd_pkg::HALF_PI_Q28 * k) / DEPTH;
      localparam longint X2 = (X * X) >>> 28;
      localparam longint T1 = ((X * X2) >>> 28) / 6;
      localparam longint T2 = ((T1 * X2) >>> 28) / 20;
      localparam longint T3 = ((T2 * X2) >>> 28) / 42;
      localparam longint T4 = ((T3 * X2) >>> 28) / 72;
      localparam longint T5 = ((T4 * X2) >>> 28) / 110;
      localparam longint T6 = ((T5 * X2) >>> 28) / 156;
      localparam longint S  = X - T1 + T2 - T3 + T4 - T5 + T6;
      localparam longint SP = (S < 0) ? 64'sd0 : S;
      localparam longint SR = (SP + 1024) >>> 11;
      localparam longint SQ = (SR > 131072) ? 64'sd131072 : SR;
      assign sine_tab[k] = lscd_pkg::TRIG_BITS'(SQ);
   end

   logic [SCW-1:0] scaled;
   logic [AW-1:0]  idx;
   logic [AW:0]    mirror;

   logic [AW-1:0]  addr_ff, addr_in;
   logic           one_ff, one_in;
   logic           neg1_ff, neg1_in;
   logic [lscd_pkg::TRIG_BITS-1:0] data_ff;
   logic           one2_ff, neg2_ff;

   assign scaled = SCW'(angle[29:0]) * SCW'(DEPTH_V);
   assign idx    = scaled[29+AW:30];
   assign mirror = DEPTH_V - (AW + 1)'(idx);

   always_comb begin
      neg1_in = angle[31];
      one_in  = 1'b0;
      addr_in = idx;
      if (angle[30]) begin
         if (idx == '0) begin
            one_in  = 1'b1;
            addr_in = '0;
         end else begin
            addr_in = mirror[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      one_ff  <= one_in;
      neg1_ff <= neg1_in;
      data_ff <= sine_tab[addr_ff];
      one2_ff <= one_ff;
      neg2_ff <= neg1_ff;
   end

   assign trig.neg = neg2_ff;
   assign trig.mag = one2_ff ? lscd_pkg::TRIG_ONE : data_ff;

endmodule

/* hdl/lscd_serial_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on lscd_pkg for the status struct.
module lscd_serial_mul #(
   parameter int WIDTH = 19
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [WIDTH-1:0]         a,
   input  logic [WIDTH-1:0]         b,
   output lscd_pkg::mul_status_type status,
   output logic [2*WIDTH-1:0]       product
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [2*WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0]   a_ff, a_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [WIDTH:0]     partial;

   // The low half holds the unused multiplier bits; the high half collects the sum.
   assign partial = {1'b0, p_ff[2*WIDTH-1:WIDTH]} + (p_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      p_in    = p_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      done_in = (cnt_ff == CNT_W'(1));
      if (start) begin
         p_in   = {{WIDTH{1'b0}}, b};
         a_in   = a;
         cnt_in = CNT_W'(WIDTH);
      end else if (cnt_ff != '0) begin
         p_in   = {partial, p_ff[WIDTH-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      p_ff <= p_in;
      a_ff <= a_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign product     = p_ff;

endmodule

/* hdl/lidar_segment_cylinder_detector_unit.sv */
// Top level of the lidar cylinder detector: sequencer, segment state, output register.
// Depends on lscd_pkg, lscd_sine_rom, lscd_serial_mul and the assertion macro header.
//
// req_ carries one range sample per transaction (tdata: range_mm, tuser: range_valid,
// tlast: scan_last). rsp_ carries at most one result per sample (tdata: center_x,
// center_y; tuser: center_found; tlast: scan_done). Registers are written on csr_.
// One sample is worked on at a time. All products go through one bit-serial
// multiplier of W = max(COORD_BITS+1, 18) bits, and that multiplier sets the rate.
// A skipped sample that ends no scan is quickest, then a segment's first point, then
// a point that joins a segment; the longest case is a break with a full chord test
// on the final sample of a scan. A sample that gives a result ends by loading the
// output register, so rsp_tvalid rises as the block turns ready for the next sample.
// The sine table is a constant ROM, so reset needs no clearing pass: it restores
// the register defaults, empties the segment and zeroes the beam offset. A result
// waits in the output register while rsp_tready is low; the next sample is still
// accepted and worked on, and the block holds its own result back until the
// output register is free.
`include "lidar_segment_cylinder_detector_unit_macros.svh"

module lidar_segment_cylinder_detector_unit #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int COORD_BITS       = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] range_mm
   input  logic        req_tuser,   // [0] range_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] center_x, [33:17] center_y, rest zero
   output logic        rsp_tuser,   // [0] center_found
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CW  = COORD_BITS;
   localparam int DW  = CW + 1;
   localparam int W   = (DW > lscd_pkg::TRIG_BITS) ? DW : lscd_pkg::TRIG_BITS;
   localparam int PW  = 2 * W;
   localparam int SW  = PW + 1;
   localparam int EXT = (CW > 17) ? CW : 17;
   localparam int RB  = lscd_pkg::RANGE_BITS;
   localparam int FR  = lscd_pkg::TRIG_FRAC;
   localparam int OB  = lscd_pkg::CENTER_BITS;

   localparam logic signed [EXT-1:0] C_MAX = EXT'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [EXT-1:0] C_MIN = EXT'(-(64'sd1 <<< (CW - 1)));
   localparam logic signed [DW-1:0]  MID_MAX = DW'(65535);
   localparam logic signed [DW-1:0]  MID_MIN = DW'(-65536);
   localparam logic [PW:0] ROUND_HALF = (PW + 1)'(1) << (FR - 1);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_COS_ADDR,
      ST_COS_ROM,
      ST_COS_START,
      ST_COS_WAIT,
      ST_SIN_ADDR,
      ST_SIN_ROM,
      ST_SIN_START,
      ST_SIN_WAIT,
      ST_POINT,
      ST_DX_WAIT,
      ST_DY_WAIT,
      ST_GAP_WAIT,
      ST_T_BEGIN,
      ST_T_CX,
      ST_T_CY,
      ST_T_HI,
      ST_T_LO,
      ST_T_END,
      ST_LAST,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [31:0] start_angle_ff;
   logic [31:0] angle_step_ff;
   logic [15:0] max_range_ff;
   logic [15:0] gap_ff;
   logic [15:0] target_ff;
   logic [15:0] tol_ff;
   logic [2:0]  min_points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= lscd_pkg::START_ANGLE_RESET;
         angle_step_ff  <= lscd_pkg::ANGLE_STEP_RESET;
         max_range_ff   <= lscd_pkg::MAX_RANGE_RESET;
         gap_ff         <= lscd_pkg::GAP_THRESHOLD_RESET;
         target_ff      <= lscd_pkg::TARGET_DIAM_RESET;
         tol_ff         <= lscd_pkg::DIAM_TOLERANCE_RESET;
         min_points_ff  <= lscd_pkg::MIN_POINTS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lscd_pkg::REG_START_ANGLE:        start_angle_ff <= csr_wdata;
            lscd_pkg::REG_ANGLE_STEP:         angle_step_ff  <= csr_wdata;
            lscd_pkg::REG_MAX_RANGE:          max_range_ff   <= csr_wdata[15:0];
            lscd_pkg::REG_GAP_THRESHOLD:      gap_ff         <= csr_wdata[15:0];
            lscd_pkg::REG_TARGET_DIAMETER:    target_ff      <= csr_wdata[15:0];
            lscd_pkg::REG_DIAMETER_TOLERANCE: tol_ff         <= csr_wdata[15:0];
            lscd_pkg::REG_MIN_POINTS:         min_points_ff  <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state.
   state_type state_ff, state_in;
   logic [RB-1:0]        range_ff, range_in;
   logic                 last_ff, last_in;
   logic [31:0]          beam_off_ff, beam_off_in;
   logic [31:0]          angle_ff, angle_in;
   logic                 neg_ff, neg_in;
   logic signed [CW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [2:0]           count_ff, count_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic                 found_ff, found_in;
   logic                 brk_ff, brk_in;
   logic [OB-1:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Sine ROM and multiplier.
   logic [31:0]              rom_angle;
   lscd_pkg::trig_type       trig;
   logic                     mul_start;
   logic [W-1:0]             mul_a, mul_b;
   lscd_pkg::mul_status_type mul_status;
   logic [PW-1:0]            mul_prod;

   assign rom_angle = (state_ff == ST_COS_ADDR) ?
                      {angle_ff[31:30] + 2'd1, angle_ff[29:0]} : angle_ff;

   lscd_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock (clock),
      .angle (rom_angle),
      .trig  (trig)
   );

   lscd_serial_mul #(
      .WIDTH (W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_status),
      .product (mul_prod)
   );

   // Coordinate from range times trig magnitude: round half up, apply sign, saturate.
   logic [PW:0]           rnd_sum;
   logic [16:0]           coord_mag;
   logic signed [EXT-1:0] coord_ext, coord_sgn, coord_sat;
   logic signed [CW-1:0]  coord_new;

   assign rnd_sum   = {1'b0, mul_prod} + ROUND_HALF;
   assign coord_mag = rnd_sum[FR+16:FR];
   assign coord_ext = signed'(EXT'(coord_mag));
   assign coord_sgn = neg_ff ? -coord_ext : coord_ext;
   assign coord_sat = (coord_sgn > C_MAX) ? C_MAX :
                      (coord_sgn < C_MIN) ? C_MIN : coord_sgn;
   assign coord_new = coord_sat[CW-1:0];

   // Differences for the gap test and the chord test.
   logic signed [DW-1:0] gdx, gdy, cdx, cdy;
   logic [DW-1:0]        gdx_mag, gdy_mag, cdx_mag, cdy_mag;

   assign gdx = DW'(px_ff) - DW'(prev_x_ff);
   assign gdy = DW'(py_ff) - DW'(prev_y_ff);
   assign cdx = DW'(prev_x_ff) - DW'(first_x_ff);
   assign cdy = DW'(prev_y_ff) - DW'(first_y_ff);
   assign gdx_mag = gdx[DW-1] ? unsigned'(-gdx) : unsigned'(gdx);
   assign gdy_mag = gdy[DW-1] ? unsigned'(-gdy) : unsigned'(gdy);
   assign cdx_mag = cdx[DW-1] ? unsigned'(-cdx) : unsigned'(cdx);
   assign cdy_mag = cdy[DW-1] ? unsigned'(-cdy) : unsigned'(cdy);

   // Chord midpoint, rounded toward minus infinity and saturated to the output width.
   logic signed [DW-1:0] mid_x_sum, mid_y_sum, mid_x, mid_y;
   logic signed [DW-1:0] mid_x_sat, mid_y_sat;

   assign mid_x_sum = DW'(first_x_ff) + DW'(prev_x_ff);
   assign mid_y_sum = DW'(first_y_ff) + DW'(prev_y_ff);
   assign mid_x     = mid_x_sum >>> 1;
   assign mid_y     = mid_y_sum >>> 1;
   assign mid_x_sat = (mid_x > MID_MAX) ? MID_MAX : (mid_x < MID_MIN) ? MID_MIN : mid_x;
   assign mid_y_sat = (mid_y > MID_MAX) ? MID_MAX : (mid_y < MID_MIN) ? MID_MIN : mid_y;

   logic [2:0]  need_points;
   logic [16:0] diam_hi;
   logic [15:0] diam_lo;
   logic        point_ok;
   logic        rsp_load;

   assign need_points = (min_points_ff < lscd_pkg::SEG_FLOOR_POINTS) ?
                        lscd_pkg::SEG_FLOOR_POINTS : min_points_ff;
   assign diam_hi  = 17'(target_ff) + 17'(tol_ff);
   assign diam_lo  = target_ff - tol_ff;
   assign point_ok = req_tuser && (req_tdata[15:0] < max_range_ff);
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      range_in     = range_ff;
      last_in      = last_ff;
      beam_off_in  = beam_off_ff;
      angle_in     = angle_ff;
      neg_in       = neg_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      found_in     = found_ff;
      brk_in       = brk_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               range_in    = req_tdata[15:0];
               last_in     = req_tlast;
               angle_in    = start_angle_ff + beam_off_ff;
               beam_off_in = beam_off_ff + angle_step_ff;
               found_in    = 1'b0;
               brk_in      = 1'b0;
               cx_in       = '0;
               cy_in       = '0;
               state_in    = point_ok ? ST_COS_ADDR : ST_LAST;
            end
         end
         ST_COS_ADDR: state_in = ST_COS_ROM;
         ST_COS_ROM:  state_in = ST_COS_START;
         ST_COS_START: begin
            mul_start = 1'b1;
            mul_a     = W'(range_ff);
            mul_b     = W'(trig.mag);
            neg_in    = trig.neg;
            state_in  = ST_COS_WAIT;
         end
         ST_COS_WAIT: begin
            if (mul_status.done) begin
               px_in    = coord_new;
               state_in = ST_SIN_ADDR;
            end
         end
         ST_SIN_ADDR: state_in = ST_SIN_ROM;
         ST_SIN_ROM:  state_in = ST_SIN_START;
         ST_SIN_START: begin
            mul_start = 1'b1;
            mul_a     = W'(range_ff);
            mul_b     = W'(trig.mag);
            neg_in    = trig.neg;
            state_in  = ST_SIN_WAIT;
         end
         ST_SIN_WAIT: begin
            if (mul_status.done) begin
               py_in    = coord_new;
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            if (count_ff == '0) begin
               first_x_in = px_ff;
               first_y_in = py_ff;
               prev_x_in  = px_ff;
               prev_y_in  = py_ff;
               count_in   = 3'd1;
               state_in   = ST_LAST;
            end else begin
               mul_start = 1'b1;
               mul_a     = W'(gdx_mag);
               mul_b     = W'(gdx_mag);
               state_in  = ST_DX_WAIT;
            end
         end
         ST_DX_WAIT: begin
            if (mul_status.done) begin
               sum_in    = SW'(mul_prod);
               mul_start = 1'b1;
               mul_a     = W'(gdy_mag);
               mul_b     = W'(gdy_mag);
               state_in  = ST_DY_WAIT;
            end
         end
         ST_DY_WAIT: begin
            if (mul_status.done) begin
               sum_in    = sum_ff + SW'(mul_prod);
               mul_start = 1'b1;
               mul_a     = W'(gap_ff);
               mul_b     = W'(gap_ff);
               state_in  = ST_GAP_WAIT;
            end
         end
         ST_GAP_WAIT: begin
            if (mul_status.done) begin
               if (sum_ff < SW'(mul_prod)) begin
                  prev_x_in = px_ff;
                  prev_y_in = py_ff;
                  if (count_ff != lscd_pkg::COUNT_MAX) begin
                     count_in = count_ff + 3'd1;
                  end
                  state_in = ST_LAST;
               end else begin
                  // The new point starts a fresh segment once the old one is tested.
                  brk_in   = 1'b1;
                  state_in = ST_T_BEGIN;
               end
            end
         end
         ST_T_BEGIN: begin
            if (count_ff < need_points) begin
               state_in = ST_T_END;
            end else begin
               mul_start = 1'b1;
               mul_a     = W'(cdx_mag);
               mul_b     = W'(cdx_mag);
               state_in  = ST_T_CX;
            end
         end
         ST_T_CX: begin
            if (mul_status.done) begin
               sum_in    = SW'(mul_prod);
               mul_start = 1'b1;
               mul_a     = W'(cdy_mag);
               mul_b     = W'(cdy_mag);
               state_in  = ST_T_CY;
            end
         end
         ST_T_CY: begin
            if (mul_status.done) begin
               sum_in    = sum_ff + SW'(mul_prod);
               mul_start = 1'b1;
               mul_a     = W'(diam_hi);
               mul_b     = W'(diam_hi);
               state_in  = ST_T_HI;
            end
         end
         ST_T_HI: begin
            if (mul_status.done) begin
               if (sum_ff > SW'(mul_prod)) begin
                  state_in = ST_T_END;
               end else if (target_ff > tol_ff) begin
                  mul_start = 1'b1;
                  mul_a     = W'(diam_lo);
                  mul_b     = W'(diam_lo);
                  state_in  = ST_T_LO;
               end else begin
                  found_in = 1'b1;
                  cx_in    = mid_x_sat[OB-1:0];
                  cy_in    = mid_y_sat[OB-1:0];
                  state_in = ST_T_END;
               end
            end
         end
         ST_T_LO: begin
            if (mul_status.done) begin
               if (sum_ff >= SW'(mul_prod)) begin
                  found_in = 1'b1;
                  cx_in    = mid_x_sat[OB-1:0];
                  cy_in    = mid_y_sat[OB-1:0];
               end
               state_in = ST_T_END;
            end
         end
         ST_T_END: begin
            if (brk_ff) begin
               first_x_in = px_ff;
               first_y_in = py_ff;
               prev_x_in  = px_ff;
               prev_y_in  = py_ff;
               count_in   = 3'd1;
               brk_in     = 1'b0;
               state_in   = ST_LAST;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LAST: begin
            // End of scan tests the open segment unless a break already found a cylinder.
            if (last_ff && !found_ff) begin
               state_in = ST_T_BEGIN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (last_ff) begin
               count_in    = '0;
               beam_off_in = '0;
            end
            state_in = (found_ff || last_ff) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, cy_ff, cx_ff};
               rsp_found_in = found_ff;
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beam_off_ff  <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         brk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beam_off_ff  <= beam_off_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      range_ff     <= range_in;
      last_ff      <= last_in;
      angle_ff     <= angle_in;
      neg_ff       <= neg_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      first_x_ff   <= first_x_in;
      first_y_ff   <= first_y_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      sum_ff       <= sum_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

   `LSCD_ASSERT_IMP(a_mul_idle_start, clock, reset, mul_start, !mul_status.busy, "multiplier restarted while busy")
   `LSCD_ASSERT_IMP(a_emit_reason, clock, reset, rsp_load, found_ff || last_ff, "result loaded without detection or end of scan")
   `LSCD_ASSERT_IMP(a_silent_needs_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast, "empty result outside end of scan")
   `LSCD_ASSERT_NEXT(a_scan_clears, clock, reset, state_ff == ST_FINISH && last_ff, count_ff == '0 && beam_off_ff == '0, "end of scan left segment state behind")

endmodule

/* tb/sv/lidar_segment_cylinder_detector_unit_checker.sv */
`timescale 1ns / 1ps
// Result checker for the lidar cylinder detector: tracks register writes, predicts each
// sample's result and compares the rsp_ stream against it. Depends on lscd_pkg only.
module lidar_segment_cylinder_detector_unit_checker #(
   parameter int SINE_DEPTH = 1024,
   parameter int COORD_W    = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] range_mm
   input  logic        req_tuser,   // [0] range_valid
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [16:0] center_x, [33:17] center_y, rest zero
   input  logic        rsp_tuser,   // [0] center_found
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_results
);
   import lscd_pkg::*;

   typedef struct {
      logic [16:0] cx;
      logic [16:0] cy;
      logic        found;
      logic        done;
   } center_report_type;

   center_report_type expected_centers[$];

   logic [31:0] cfg_start_angle;
   logic [31:0] cfg_angle_step;
   logic [15:0] cfg_max_range;
   logic [15:0] cfg_gap;
   logic [15:0] cfg_target;
   logic [15:0] cfg_tolerance;
   logic [2:0]  cfg_min_points;

   logic [31:0] beam_offset;
   longint      seg_first_x, seg_first_y, seg_last_x, seg_last_y;
   int          seg_points;
   int          quarter_sine[SINE_DEPTH];

   // Quarter-wave sine entry in Q17, from a Taylor series evaluated in Q28.
   function automatic int taylor_q17(int k);
      longint x, x2, term, acc;
      int     n;
      x    = (HALF_PI_Q28 * longint'(k)) / SINE_DEPTH;
      x2   = (x * x) >>> 28;
      term = x;
      acc  = x;
      for (n = 1; n <= 6; n++) begin
         term = (term * x2) >>> 28;
         term = term / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc -= term;
         end else begin
            acc += term;
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 1024) >>> 11;
      if (acc > longint'(TRIG_ONE)) begin
         acc = longint'(TRIG_ONE);
      end
      return int'(acc);
   endfunction

   function automatic longint beam_sine(logic [31:0] a);
      longint idx, m;
      idx = (longint'(a[29:0]) * SINE_DEPTH) >>> 30;
      if (idx >= SINE_DEPTH) begin
         idx = SINE_DEPTH - 1;
      end
      if (!a[30]) begin
         m = quarter_sine[idx];
      end else begin
         m = (idx == 0) ? longint'(TRIG_ONE) : longint'(quarter_sine[SINE_DEPTH - idx]);
      end
      return a[31] ? -m : m;
   endfunction

   // Range times trig in Q17, rounded half away from zero, clamped to the coordinate width.
   function automatic longint project(logic [15:0] range, longint trig);
      longint mag, v, lim;
      mag = longint'(range) * ((trig < 0) ? -trig : trig);
      v   = (mag + 65536) >>> 17;
      if (trig < 0) begin
         v = -v;
      end
      lim = longint'(1) << (COORD_W - 1);
      if (v > lim - 1) begin
         v = lim - 1;
      end
      if (v < -lim) begin
         v = -lim;
      end
      return v;
   endfunction

   function automatic longint clamp17(longint v);
      if (v > 65535) begin
         return 65535;
      end
      if (v < -65536) begin
         return -65536;
      end
      return v;
   endfunction

   function automatic bit chord_matches(output longint mx, output longint my);
      longint need, dx, dy, c2, hi, lo;
      mx   = 0;
      my   = 0;
      need = (cfg_min_points < 2) ? 2 : longint'(cfg_min_points);
      if (seg_points < need) begin
         return 0;
      end
      dx = seg_last_x - seg_first_x;
      dy = seg_last_y - seg_first_y;
      c2 = dx * dx + dy * dy;
      hi = longint'(cfg_target) + longint'(cfg_tolerance);
      if (c2 > hi * hi) begin
         return 0;
      end
      // The lower bound only applies when the tolerance is smaller than the target.
      if (cfg_target > cfg_tolerance) begin
         lo = longint'(cfg_target) - longint'(cfg_tolerance);
         if (c2 < lo * lo) begin
            return 0;
         end
      end
      mx = clamp17((seg_first_x + seg_last_x) >>> 1);
      my = clamp17((seg_first_y + seg_last_y) >>> 1);
      return 1;
   endfunction

   task automatic absorb_sample(logic [15:0] range, logic valid, logic last);
      logic [31:0]       angle;
      longint            px, py, dx, dy, cx, cy;
      bit                found;
      center_report_type rep;
      angle = cfg_start_angle + beam_offset;
      found = 0;
      cx    = 0;
      cy    = 0;
      beam_offset += cfg_angle_step;
      if (valid && range < cfg_max_range) begin
         px = project(range, beam_sine(angle + 32'h4000_0000));
         py = project(range, beam_sine(angle));
         if (seg_points == 0) begin
            seg_first_x = px;
            seg_first_y = py;
            seg_last_x  = px;
            seg_last_y  = py;
            seg_points  = 1;
         end else begin
            dx = px - seg_last_x;
            dy = py - seg_last_y;
            if (dx * dx + dy * dy < longint'(cfg_gap) * longint'(cfg_gap)) begin
               seg_last_x = px;
               seg_last_y = py;
               if (seg_points < 7) begin
                  seg_points++;
               end
            end else begin
               found       = chord_matches(cx, cy);
               seg_first_x = px;
               seg_first_y = py;
               seg_last_x  = px;
               seg_last_y  = py;
               seg_points  = 1;
            end
         end
      end
      if (last) begin
         if (!found) begin
            found = chord_matches(cx, cy);
         end
         seg_points  = 0;
         beam_offset = '0;
      end
      if (found || last) begin
         rep.cx    = found ? cx[16:0] : '0;
         rep.cy    = found ? cy[16:0] : '0;
         rep.found = found;
         rep.done  = last;
         expected_centers = {expected_centers, rep};
      end
   endtask

   task automatic check_center();
      center_report_type exp_rep;
      if (expected_centers.size() == 0) begin
         $error("unexpected result transaction: center_x %0d center_y %0d found %0b done %0b",
                $signed(rsp_tdata[16:0]), $signed(rsp_tdata[33:17]), rsp_tuser, rsp_tlast);
         mismatch_count++;
         return;
      end
      exp_rep = expected_centers.pop_front();
      if (rsp_tdata[16:0] !== exp_rep.cx) begin
         $error("center_x mismatch: expected %0d, actual %0d",
                $signed(exp_rep.cx), $signed(rsp_tdata[16:0]));
         mismatch_count++;
      end
      if (rsp_tdata[33:17] !== exp_rep.cy) begin
         $error("center_y mismatch: expected %0d, actual %0d",
                $signed(exp_rep.cy), $signed(rsp_tdata[33:17]));
         mismatch_count++;
      end
      if (rsp_tuser !== exp_rep.found) begin
         $error("center_found mismatch: expected %0b, actual %0b", exp_rep.found, rsp_tuser);
         mismatch_count++;
      end
      if (rsp_tlast !== exp_rep.done) begin
         $error("scan_done mismatch: expected %0b, actual %0b", exp_rep.done, rsp_tlast);
         mismatch_count++;
      end
      if (rsp_tdata[39:34] !== 6'd0) begin
         $error("tdata padding mismatch: expected 0, actual %0h", rsp_tdata[39:34]);
         mismatch_count++;
      end
   endtask

   task automatic apply_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
         REG_START_ANGLE:        cfg_start_angle = data;
         REG_ANGLE_STEP:         cfg_angle_step  = data;
         REG_MAX_RANGE:          cfg_max_range   = data[15:0];
         REG_GAP_THRESHOLD:      cfg_gap         = data[15:0];
         REG_TARGET_DIAMETER:    cfg_target      = data[15:0];
         REG_DIAMETER_TOLERANCE: cfg_tolerance   = data[15:0];
         REG_MIN_POINTS:         cfg_min_points  = data[2:0];
         default: ;
      endcase
   endtask

   initial begin
      int k;
      mismatch_count  = 0;
      pending_results = 0;
      for (k = 0; k < SINE_DEPTH; k++) begin
         quarter_sine[k] = taylor_q17(k);
      end
   end

   // Results are compared before the same edge's sample is predicted, so a result
   // can never be matched against an expectation created in the same cycle.
   always @(posedge clock) begin
      if (reset) begin
         cfg_start_angle = START_ANGLE_RESET;
         cfg_angle_step  = ANGLE_STEP_RESET;
         cfg_max_range   = MAX_RANGE_RESET;
         cfg_gap         = GAP_THRESHOLD_RESET;
         cfg_target      = TARGET_DIAM_RESET;
         cfg_tolerance   = DIAM_TOLERANCE_RESET;
         cfg_min_points  = MIN_POINTS_RESET;
         beam_offset     = '0;
         seg_first_x     = 0;
         seg_first_y     = 0;
         seg_last_x      = 0;
         seg_last_y      = 0;
         seg_points      = 0;
         expected_centers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_center();
         end
         if (csr_we) begin
            apply_register(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            absorb_sample(req_tdata, req_tuser, req_tlast);
         end
      end
      pending_results = expected_centers.size();
   end

endmodule

/* tb/sv/lidar_segment_cylinder_detector_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the lidar cylinder detector testbench: clock, reset, register setup and sample
// stimulus. Depends on lscd_pkg, the detector and lidar_segment_cylinder_detector_unit_checker.
module lidar_segment_cylinder_detector_unit_tb;
   import lscd_pkg::*;

   localparam logic [2:0] UNMAPPED_REG     = 3'd7;
   localparam int         PHASE_COUNT      = 10;
   localparam int         PHASE_SAMPLES    = 75;
   localparam int         LONG_HOLD_CYCLES = 600;
   localparam int         SETTLE_CYCLES    = 300;
   localparam logic [31:0] HALF_DEGREE     = 32'd5965232;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] range_mm
   logic        req_tuser  = 1'b0; // [0] range_valid
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [16:0] center_x, [33:17] center_y, rest zero
   logic        rsp_tuser;         // [0] center_found
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   int mismatch_count;
   int pending_results;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int hold_seq        = 0;
   int hold_taken      = 0;
   int hold_left       = 0;
   int phase_samples   = 0;

   // Register values last written, used to shape the scans.
   logic [31:0] cur_step   = ANGLE_STEP_RESET;
   logic [15:0] cur_max    = MAX_RANGE_RESET;
   logic [15:0] cur_gap    = GAP_THRESHOLD_RESET;
   logic [15:0] cur_target = TARGET_DIAM_RESET;

   always #10 clock = ~clock;

   lidar_segment_cylinder_detector_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lidar_segment_cylinder_detector_unit_checker center_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_seq != hold_taken) begin
         hold_taken = hold_seq;
         hold_left  = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Entered and left at a falling edge; the transaction completes at a rising edge between.
   task automatic offer_sample(logic [15:0] range, logic valid, logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= range;
      req_tuser  <= valid;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
      phase_samples++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Lets the block drain: every expected result in, then time for a silent sample to finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure_phase(int p);
      logic [31:0] start_a, step_a;
      logic [15:0] max_r, gap_r, tgt_r, tol_r, pad16;
      logic [28:0] pad29;
      logic [2:0]  mp;
      pad16 = (p == 7 || p == 8) ? 16'($urandom) : 16'd0;
      pad29 = (p == 7 || p == 8) ? 29'($urandom) : 29'd0;
      case (p)
         1: begin
            start_a = 32'd0;          step_a = HALF_DEGREE;
            max_r = 16'd65535;        gap_r = 16'd900;
            tgt_r = 16'd300;          tol_r = 16'd50;     mp = 3'd4;
         end
         2: begin
            start_a = 32'h4000_0000;  step_a = 32'd11930465;
            max_r = 16'd20000;        gap_r = 16'd400;
            tgt_r = 16'd500;          tol_r = 16'd100;    mp = 3'd3;
         end
         3: begin
            // Most negative start angle with a step that walks backwards.
            start_a = 32'h8000_0000;  step_a = 32'd0 - HALF_DEGREE;
            max_r = 16'd65535;        gap_r = 16'd65535;
            tgt_r = 16'd300;          tol_r = 16'd0;      mp = 3'd7;
         end
         4: begin
            // A zero maximum range skips every sample.
            start_a = 32'h7FFF_FFFF;  step_a = 32'd2982616;
            max_r = 16'd0;            gap_r = 16'd900;
            tgt_r = 16'd65535;        tol_r = 16'd65535;  mp = 3'd2;
         end
         5: begin
            // A zero gap threshold breaks the segment at every point.
            start_a = $urandom;       step_a = HALF_DEGREE;
            max_r = 16'd30000;        gap_r = 16'd0;
            tgt_r = 16'd0;            tol_r = 16'd20;     mp = 3'd1;
         end
         6: begin
            start_a = $urandom;       step_a = 32'd0;
            max_r = 16'd65535;        gap_r = 16'd1500;
            tgt_r = 16'd200;          tol_r = 16'd300;    mp = 3'd0;
         end
         7, 8: begin
            start_a = $urandom;       step_a = $urandom_range(2000000, 12000000);
            max_r = 16'($urandom_range(8000, 65535));
            gap_r = 16'($urandom_range(200, 3000));
            tgt_r = 16'($urandom_range(100, 1500));
            tol_r = 16'($urandom_range(0, 200));
            mp    = 3'($urandom_range(2, 7));
         end
         9: begin
            start_a = 32'hC000_0000;  step_a = 32'hFFFF_FFFF;
            max_r = MAX_RANGE_RESET;  gap_r = GAP_THRESHOLD_RESET;
            tgt_r = TARGET_DIAM_RESET; tol_r = DIAM_TOLERANCE_RESET; mp = MIN_POINTS_RESET;
         end
         default: begin
            start_a = $urandom;       step_a = 32'd8947849;
            max_r = 16'd65535;        gap_r = 16'd1000;
            tgt_r = 16'd400;          tol_r = 16'd80;     mp = 3'd5;
         end
      endcase
      write_reg(REG_START_ANGLE, start_a);
      write_reg(REG_ANGLE_STEP, step_a);
      write_reg(REG_MAX_RANGE, {pad16, max_r});
      write_reg(REG_GAP_THRESHOLD, {pad16, gap_r});
      write_reg(REG_TARGET_DIAMETER, {pad16, tgt_r});
      write_reg(REG_DIAMETER_TOLERANCE, {pad16, tol_r});
      write_reg(REG_MIN_POINTS, {pad29, mp});
      if (p == 7) begin
         write_reg(UNMAPPED_REG, $urandom);
      end
      csr_we     <= 1'b0;
      cur_step   = step_a;
      cur_max    = max_r;
      cur_gap    = gap_r;
      cur_target = tgt_r;
   endtask

   // Something that is not part of the object: far away, invalid or beyond the maximum range.
   task automatic send_background(int far, logic last);
      int kind;
      kind = $urandom_range(0, 2);
      if (kind == 1 || far > 65535) begin
         offer_sample(16'($urandom), 1'b0, last);
      end else if (kind == 2 && cur_max < 16'hFFFF) begin
         offer_sample(16'($urandom_range(cur_max, 65535)), 1'b1, last);
      end else begin
         offer_sample(16'(far), 1'b1, last);
      end
   endtask

   // One scan with a cylinder-sized object whose width in beams is set from the target.
   task automatic send_scan();
      int  lead, trail, k, r0, ramp, far, j, rr;
      real turns, arc;
      lead  = $urandom_range(0, 5);
      trail = $urandom_range(0, 4);
      r0    = $urandom_range(300, 6000);
      turns = (cur_step >= 32'h8000_0000) ? 4294967296.0 - real'(cur_step) : real'(cur_step);
      turns = turns / 4294967296.0;
      arc   = real'(r0) * 6.283185 * turns;
      ramp  = 0;
      if (arc < 0.5) begin
         // Beams nearly share one direction, so the chord comes from a range ramp.
         k    = $urandom_range(2, 10);
         ramp = int'(cur_target) / (k - 1);
      end else begin
         k = 1 + $rtoi(real'(cur_target) / arc + 0.5) + int'($urandom_range(0, 2)) - 1;
      end
      if (k < 2) begin
         k = 2;
      end
      if (k > 40) begin
         k = 40;
      end
      far = r0 + int'(cur_gap) + 300 + int'($urandom_range(0, 3000));
      for (j = 0; j < lead; j++) begin
         send_background(far, 1'b0);
      end
      for (j = 0; j < k; j++) begin
         if ($urandom_range(0, 19) == 0) begin
            offer_sample(16'($urandom), 1'b0, 1'b0);
         end
         rr = r0 + j * ramp + int'($urandom_range(0, 6)) - 3;
         offer_sample((rr > 65535) ? 16'hFFFF : 16'(rr), 1'b1, trail == 0 && j == k - 1);
      end
      for (j = 0; j < trail; j++) begin
         send_background(far, j == trail - 1);
      end
   endtask

   task automatic send_noise();
      int n, j;
      n = $urandom_range(1, 4);
      for (j = 0; j < n; j++) begin
         offer_sample(16'($urandom), 1'($urandom), $urandom_range(0, 7) == 0);
      end
   endtask

   // Default registers: zero angle and step put every point on the x axis at x = range.
   task automatic send_directed();
      offer_sample(16'd0, 1'b1, 1'b0);
      offer_sample(16'd65535, 1'b1, 1'b0);
      offer_sample(16'd12345, 1'b0, 1'b0);
      offer_sample(16'd100, 1'b1, 1'b0);
      offer_sample(16'd200, 1'b1, 1'b0);
      offer_sample(16'd400, 1'b1, 1'b1);
      offer_sample(16'd1000, 1'b1, 1'b0);
      offer_sample(16'd1100, 1'b1, 1'b0);
      offer_sample(16'd1200, 1'b1, 1'b0);
      offer_sample(16'd1300, 1'b1, 1'b1);
      offer_sample(16'd1000, 1'b1, 1'b0);
      offer_sample(16'd1010, 1'b1, 1'b0);
      offer_sample(16'd1020, 1'b1, 1'b0);
      offer_sample(16'd1030, 1'b1, 1'b0);
      offer_sample(16'd5000, 1'b1, 1'b0);
      offer_sample(16'd5100, 1'b1, 1'b0);
      offer_sample(16'd5200, 1'b1, 1'b0);
      offer_sample(16'd5300, 1'b1, 1'b0);
      offer_sample(16'd9000, 1'b1, 1'b0);
      offer_sample(16'd65534, 1'b1, 1'b1);
      offer_sample(16'd2000, 1'b1, 1'b0);
      offer_sample(16'd2150, 1'b1, 1'b0);
      offer_sample(16'd2300, 1'b1, 1'b1);
      offer_sample(16'd0, 1'b0, 1'b1);
   endtask

   initial begin
      int  p;
      bit  paused;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_directed();
      for (p = 1; p <= PHASE_COUNT; p++) begin
         settle();
         configure_phase(p);
         case (p % 4)
            1: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 59; rsp_stall_pct = 0;  end
            3: begin sender_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin sender_idle_pct = 34; rsp_stall_pct = 34; end
         endcase
         if (p == 1) begin
            hold_seq++;
         end
         phase_samples = 0;
         paused        = 0;
         while (phase_samples < PHASE_SAMPLES) begin
            if ($urandom_range(0, 4) == 0) begin
               send_noise();
            end else begin
               send_scan();
            end
            if (p == 2 && !paused && phase_samples >= PHASE_SAMPLES / 2) begin
               // Sender pause until the block has handed over everything it owes.
               req_tvalid <= 1'b0;
               while (pending_results != 0) begin
                  @(negedge clock);
               end
               paused = 1;
            end
         end
      end
      settle();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
